### sv/lfia_pkg.sv
// Shared types and constants for the lowest free descriptor allocator.
package lfia_pkg;

    localparam int WORD_BITS = 64;
    localparam int POS_W     = 6;
    localparam int ID_W      = 10;
    localparam int STATUS_W  = 2;
    localparam int FUNC_W    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_LOOKUP = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOT_HELD = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_RESP
    } state_t;

endpackage

### sv/lfia_ffz.sv
// Find-first-zero unit over one bitmap word, shared by every step of a scan.
module lfia_ffz
    import lfia_pkg::*;
(
    input  logic [WORD_BITS-1:0] held,
    output logic                 found,
    output logic [POS_W-1:0]     pos
);

    // Walk from the top so that the lowest clear bit wins.
    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!held[i])
            begin
                found = 1'b1;
                pos   = POS_W'(i);
            end
        end
    end

endmodule

### sv/lowest_free_id_allocator.sv
// Top level of the lowest free descriptor allocator: sequencer, bitmap memory and output stage.
//
// The block hands out descriptor numbers from 0 to NUM_IDS-1, always the lowest free one, and
// takes them back on a free request; a lookup request reports whether a number is held. The
// occupancy bitmap sits in a memory of 64-bit words. After reset the block clears that memory,
// one word a cycle, and accepts no request meanwhile. An allocate request examines the bitmap
// words in turn, starting at the word that holds the low-water hint, because a single 64-bit
// find-first-zero unit looks at one word a cycle. Free and lookup requests pass through one
// memory read, one check and a hand-over of the result to the output register. A result that
// has not yet been taken does not stop the next request from being accepted; only its
// delivery waits.
module lowest_free_id_allocator
    import lfia_pkg::*;
#(
    parameter int NUM_IDS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] id_in, [15:10] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [9:0] id_out, [11:10] status, [15:12] zero
);

    localparam int WORDS     = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NW        = WAW + POS_W;
    localparam int HW        = $clog2(NUM_IDS + 1);
    localparam int TAIL_BITS = NUM_IDS % WORD_BITS;
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    // Bits of the last word that lie beyond the table count as permanently held.
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        (TAIL_BITS == 0) ? '0 : ~((WORD_BITS'(1) << TAIL_BITS) - WORD_BITS'(1));

    state_t                state_reg, state_next;
    logic [WAW-1:0]        clr_reg, clr_next;
    logic [HW-1:0]         hint_reg, hint_next;
    logic                  out_valid_reg, out_valid_next;

    logic [WAW-1:0]        ptr_reg, ptr_next;
    logic                  first_reg, first_next;
    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    status_t               res_st_reg, res_st_next;
    logic [15:0]           out_data_reg, out_data_next;

    logic [WORD_BITS-1:0]  mem [WORDS];
    logic [WORD_BITS-1:0]  rdata_reg;
    logic [WAW-1:0]        rd_addr;
    logic                  wr_en;
    logic [WAW-1:0]        wr_addr;
    logic [WORD_BITS-1:0]  wr_data;

    logic [WORD_BITS-1:0]  low_mask;
    logic [WORD_BITS-1:0]  held_word;
    logic                  ffz_found;
    logic [POS_W-1:0]      ffz_pos;
    logic [NW-1:0]         found_num;

    logic [ID_W-1:0]       in_id;
    logic                  in_range;
    logic                  in_accept;
    logic                  hint_full;
    logic [WAW-1:0]        hint_word;
    logic [WAW-1:0]        in_word;
    logic                  reg_in_range;
    logic                  reg_held;

    assign in_id     = s_axis_tdata[ID_W-1:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_range  = 32'(in_id) < 32'(NUM_IDS);
    assign hint_full = hint_reg == HW'(NUM_IDS);
    assign hint_word = hint_full ? '0 : WAW'(hint_reg >> POS_W);
    assign in_word   = in_range ? WAW'(in_id >> POS_W) : '0;

    // On the first word of a scan everything below the hint is known to be taken.
    assign low_mask  = (WORD_BITS'(1) << 6'(hint_reg)) - WORD_BITS'(1);
    assign held_word = rdata_reg
                     | (first_reg ? low_mask : '0)
                     | ((ptr_reg == LAST_WORD) ? TAIL_MASK : '0);
    assign found_num = {ptr_reg, ffz_pos};

    assign reg_in_range = 32'(id_reg) < 32'(NUM_IDS);
    assign reg_held     = reg_in_range && rdata_reg[id_reg[POS_W-1:0]];

    lfia_ffz u_ffz
    (
        .held  (held_word),
        .found (ffz_found),
        .pos   (ffz_pos)
    );

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        hint_next      = hint_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        out_data_next  = out_data_reg;
        rd_addr        = ptr_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = rdata_reg;
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = WAW'(clr_reg + 1'b1);
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                rd_addr = (s_axis_tuser == FUNC_ALLOC) ? hint_word : in_word;
                if (in_accept)
                begin
                    func_next  = s_axis_tuser;
                    id_next    = in_id;
                    ptr_next   = rd_addr;
                    first_next = 1'b1;
                    if (s_axis_tuser == FUNC_ALLOC)
                    begin
                        if (hint_full)
                        begin
                            res_id_next = '0;
                            res_st_next = STATUS_FULL;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_SCAN:
            begin
                // Fetch the following word while this one is being searched.
                first_next = 1'b0;
                rd_addr    = (ptr_reg == LAST_WORD) ? ptr_reg : WAW'(ptr_reg + 1'b1);
                if (ffz_found)
                begin
                    wr_en       = 1'b1;
                    wr_data     = rdata_reg | (WORD_BITS'(1) << ffz_pos);
                    hint_next   = HW'({1'b0, found_num} + 1'b1);
                    res_id_next = ID_W'(found_num);
                    res_st_next = STATUS_OK;
                    state_next  = ST_RESP;
                end
                else if (ptr_reg == LAST_WORD)
                begin
                    res_id_next = '0;
                    res_st_next = STATUS_FULL;
                    state_next  = ST_RESP;
                end
                else
                begin
                    ptr_next = WAW'(ptr_reg + 1'b1);
                end
            end

            ST_CHECK:
            begin
                res_id_next = id_reg;
                res_st_next = reg_held ? STATUS_OK : STATUS_NOT_HELD;
                if ((func_reg == FUNC_FREE) && reg_held)
                begin
                    wr_en   = 1'b1;
                    wr_data = rdata_reg & ~(WORD_BITS'(1) << id_reg[POS_W-1:0]);
                    if (32'(id_reg) < 32'(hint_reg))
                    begin
                        hint_next = HW'(id_reg);
                    end
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, res_st_reg, res_id_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        first_reg    <= first_next;
        func_reg     <= func_next;
        id_reg       <= id_next;
        res_id_reg   <= res_id_next;
        res_st_reg   <= res_st_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
